// ----- hw/rtl/bra_pkg.sv -----
// Package: command codes, sequencer states and shared types of the bitmap run allocator.
`default_nettype none
package bra_pkg;

  typedef enum logic [3:0] {
    CMD_SET_BIT     = 4'd0,
    CMD_CLR_BIT     = 4'd1,
    CMD_SET_RANGE   = 4'd2,
    CMD_CLR_RANGE   = 4'd3,
    CMD_SET_ALL     = 4'd4,
    CMD_CLR_ALL     = 4'd5,
    CMD_TEST        = 4'd6,
    CMD_FIND_SET    = 4'd7,
    CMD_FIND_CLR    = 4'd8,
    CMD_FIRST_SET   = 4'd9,
    CMD_FIRST_CLR   = 4'd10,
    CMD_RANGE_SET   = 4'd11,
    CMD_RANGE_CLR   = 4'd12,
    CMD_NOP13       = 4'd13,
    CMD_NOP14       = 4'd14,
    CMD_NOP15       = 4'd15
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WORK,
    ST_OUT
  } state_e;

  // Operation class handed from the sequencer to the word unit
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CHECK,
    OP_FIND
  } op_e;

  typedef struct packed {
    op_e  op;
    logic val;
  } unit_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bra_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module bra_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write, and read registered; the read returns the word held before the write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bra_word_unit.sv -----
// Shared word unit: masks one word against the bit window and updates, checks or scans it.
`default_nettype none
module bra_word_unit #(
  parameter int WordBits = 64,
  parameter int PosW     = 13
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  step_i,
  input  wire bra_pkg::unit_ctl_t    ctl_i,
  input  wire logic [PosW-1:0]       base_i,
  input  wire logic [PosW-1:0]       lo_i,
  input  wire logic [PosW-1:0]       hi_i,
  input  wire logic [PosW-1:0]       len_i,
  input  wire logic [WordBits-1:0]   word_i,
  output logic      [WordBits-1:0]   word_o,
  output logic                       fail_o,
  output logic                       found_o,
  output logic      [PosW-1:0]       found_pos_o
);
  import bra_pkg::*;

  logic [PosW-1:0] run_q, run_d;
  logic            fail_q, fail_d;
  logic            found_q, found_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [WordBits-1:0] win;
  logic [WordBits-1:0] match;
  logic [PosW:0]       run_at [WordBits];
  logic [WordBits-1:0] hit_at;

  // Build the window mask of bits inside [lo, hi) and the in-window matches
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      win[i]   = (base_i + PosW'(i) >= lo_i) && (base_i + PosW'(i) < hi_i);
      match[i] = win[i] && (word_i[i] == ctl_i.val);
    end
  end

  // Run length ending at each bit: from the last break, or carried in when none
  always_comb begin
    logic            brk;
    logic [PosW-1:0] kz;
    for (int i = 0; i < WordBits; i++) begin
      brk = 1'b0;
      kz  = '0;
      for (int j = 0; j <= i; j++) begin
        if (!match[j]) begin
          brk = 1'b1;
          kz  = PosW'(j);
        end
      end
      run_at[i] = brk ? {1'b0, PosW'(i) - kz} : {1'b0, run_q} + (PosW+1)'(i + 1);
      hit_at[i] = (run_at[i] >= {1'b0, len_i});
    end
  end

  // Apply the operation to the word
  always_comb begin
    logic            hit_any;
    logic [PosW-1:0] first_i;
    hit_any = 1'b0;
    first_i = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (hit_at[i]) begin
        hit_any = 1'b1;
        first_i = PosW'(i);
      end
    end
    word_o  = word_i;
    fail_d  = fail_q;
    run_d   = run_q;
    found_d = found_q;
    pos_d   = pos_q;
    case (ctl_i.op)
      OP_WRITE: begin
        for (int i = 0; i < WordBits; i++) begin
          if (win[i]) word_o[i] = ctl_i.val;
        end
      end
      OP_CHECK: begin
        if ((win & ~match) != '0) fail_d = 1'b1;
      end
      OP_FIND: begin
        if (!found_q) begin
          if (hit_any) begin
            found_d = 1'b1;
            pos_d   = base_i + first_i + PosW'(1) - len_i;
          end else begin
            run_d = run_at[WordBits-1][PosW-1:0];
          end
        end
      end
      default: ;
    endcase
    if (start_i) begin
      run_d = '0; fail_d = 1'b0; found_d = 1'b0; pos_d = '0;
    end
  end

  // Hold scan state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0; fail_q <= 1'b0; found_q <= 1'b0; pos_q <= '0;
    end else if (start_i || step_i) begin
      run_q <= run_d; fail_q <= fail_d; found_q <= found_d; pos_q <= pos_d;
    end
  end

  // Report the state including the word now in the unit
  assign fail_o      = fail_d;
  assign found_o     = found_d;
  assign found_pos_o = pos_d;
endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_run_allocator_core.sv -----
// Top level: command sequencer around the bitmap RAM and the shared word unit.
// Sequencing: one-word commands (bit writes, tests, trivial searches, unused codes) read and
// work on a single word before the result; range, run and whole-map commands pass through
// the read and work states for every word of the map.
// Throughput: one item at a time; ready again the cycle after the result is taken.
// Reset: async, active low; a clearing pass zeroes every RAM word first.
`default_nettype none
module bitmap_run_allocator_core #(
  parameter int NBITS     = 4096,
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] command, [15:4] bit_index, [28:16] run_length, [31:29] zero
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] hit, [13:1] position, [15:14] zero
  output logic      [15:0] m_axis_tdata
);
  import bra_pkg::*;

  localparam int NWords = NBITS / WORD_BITS;
  localparam int AW     = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int PosW   = 13;
  localparam int OffW   = $clog2(WORD_BITS);
  localparam logic [PosW-1:0] NbitsP = PosW'(NBITS);

  state_e st_q, st_d;
  logic [PosW-1:0] size_q;
  cmd_e            cmd_q, cmd_d;
  logic [PosW-1:0] idx_q, idx_d, len_q, len_d, lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]   addr_q, addr_d, last_q, last_d;
  logic            hit_q, hit_d;
  logic [PosW-1:0] pos_q, pos_d;
  unit_ctl_t       ctl_q, ctl_d;
  logic            start;
  logic            we;
  logic [WORD_BITS-1:0] rdata, wdata, ram_wdata;
  logic            fail, found;
  logic [PosW-1:0] found_pos;
  logic [PosW-1:0] size_eff;
  logic [3:0]      in_cmd;
  logic [PosW-1:0] in_idx, in_len, rstart;
  logic [PosW:0]   in_end;
  logic            acc;

  // Clamp the in-use size to 1..NBITS
  always_comb begin
    if (cfg_wdata_i == '0)          size_eff = PosW'(1);
    else if (cfg_wdata_i > NbitsP)  size_eff = NbitsP;
    else                            size_eff = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       size_q <= NbitsP;
    else if (cfg_we_i) size_q <= size_eff;
  end

  // Write zeros during the clearing pass
  assign ram_wdata = (st_q == ST_CLEAR) ? '0 : wdata;

  bra_ram #(.Width(WORD_BITS), .Depth(NWords)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr_q), .wdata_i(ram_wdata), .rdata_o(rdata)
  );

  bra_word_unit #(.WordBits(WORD_BITS), .PosW(PosW)) u_unit (
    .clk_i, .rst_ni, .start_i(start), .step_i(st_q == ST_WORK), .ctl_i(ctl_q),
    .base_i(PosW'({addr_q, OffW'(0)})), .lo_i(lo_q), .hi_i(hi_q), .len_i(len_q),
    .word_i(rdata), .word_o(wdata), .fail_o(fail), .found_o(found),
    .found_pos_o(found_pos)
  );

  // Unpack the input item
  assign in_cmd = s_axis_tdata[3:0];
  assign in_idx = {1'b0, s_axis_tdata[15:4]};
  assign in_len = s_axis_tdata[28:16];
  assign in_end = {1'b0, in_idx} + {1'b0, in_len};
  assign rstart = (in_idx >= size_q) ? '0 : in_idx;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata  = {2'b00, pos_q, hit_q};

  // Sequencer: decode an accepted item, walk the words, form the result
  always_comb begin
    st_d   = st_q;
    addr_d = addr_q;
    last_d = last_q;
    hit_d  = hit_q;
    pos_d  = pos_q;
    cmd_d  = cmd_q;
    idx_d  = idx_q;
    len_d  = len_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    ctl_d  = ctl_q;
    we     = 1'b0;
    start  = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(NWords - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          start  = 1'b1;
          st_d   = ST_READ;
          addr_d = '0;
          last_d = AW'(NWords - 1);
          pos_d  = '0;
          hit_d  = 1'b0;
          cmd_d  = cmd_e'(in_cmd);
          idx_d  = in_idx;
          len_d  = in_len;
          lo_d   = in_idx;
          hi_d   = (in_end > {1'b0, size_q}) ? size_q : in_end[PosW-1:0];
          ctl_d  = '{op: OP_WRITE, val: 1'b0};
          case (cmd_e'(in_cmd))
            CMD_SET_BIT, CMD_CLR_BIT: begin
              addr_d = in_idx[OffW +: AW];
              last_d = in_idx[OffW +: AW];
              ctl_d  = '{op: OP_WRITE, val: !in_cmd[0]};
              hi_d   = (in_idx < size_q) ? in_idx + PosW'(1) : in_idx;
            end
            CMD_SET_RANGE, CMD_CLR_RANGE:
              ctl_d = '{op: OP_WRITE, val: !in_cmd[0]};
            CMD_SET_ALL, CMD_CLR_ALL: begin
              ctl_d = '{op: OP_WRITE, val: !in_cmd[0]};
              lo_d  = '0;
              hi_d  = size_q;
            end
            CMD_TEST: begin
              addr_d = in_idx[OffW +: AW];
              last_d = in_idx[OffW +: AW];
              ctl_d  = '{op: OP_CHECK, val: 1'b1};
              hi_d   = in_idx;
              pos_d  = in_idx;
              hit_d  = (in_idx < size_q);
            end
            CMD_FIND_SET, CMD_FIND_CLR: begin
              ctl_d = '{op: OP_FIND, val: (in_cmd == CMD_FIND_SET)};
              lo_d  = rstart;
              hi_d  = size_q;
              if (in_len > size_q || in_len == '0) begin
                ctl_d  = '{op: OP_CHECK, val: 1'b0};
                hi_d   = '0;
                last_d = '0;
                if (in_len == '0) begin
                  hit_d = 1'b1;
                  pos_d = {rstart[PosW-1:3], 3'b000};
                end else begin
                  pos_d = size_q;
                end
              end
            end
            CMD_FIRST_SET, CMD_FIRST_CLR: begin
              ctl_d = '{op: OP_FIND, val: (in_cmd == CMD_FIRST_SET)};
              len_d = PosW'(1);
              lo_d  = '0;
              hi_d  = size_q;
            end
            CMD_RANGE_SET, CMD_RANGE_CLR: begin
              ctl_d = '{op: OP_CHECK, val: (in_cmd == CMD_RANGE_SET)};
              pos_d = in_idx;
              hit_d = (in_len != '0) && (in_end <= {1'b0, size_q});
            end
            default: begin
              ctl_d  = '{op: OP_CHECK, val: 1'b0};
              hi_d   = '0;
              last_d = '0;
            end
          endcase
        end
      end
      ST_READ: st_d = ST_WORK;
      ST_WORK: begin
        we = (ctl_q.op == OP_WRITE);
        if (cmd_q == CMD_TEST) hit_d = hit_q && rdata[idx_q[OffW-1:0]];
        if (addr_q == last_q) begin
          st_d = ST_OUT;
          if (ctl_q.op == OP_FIND) begin
            hit_d = found;
            pos_d = found ? found_pos : size_q;
          end else if (ctl_q.op == OP_CHECK) begin
            hit_d = hit_d && !fail;
          end
        end else begin
          addr_d = addr_q + 1'b1;
          st_d   = ST_READ;
        end
      end
      ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      addr_q <= '0;
      last_q <= '0;
      hit_q  <= 1'b0;
      pos_q  <= '0;
      cmd_q  <= CMD_SET_BIT;
      idx_q  <= '0;
      len_q  <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      ctl_q  <= '{op: OP_WRITE, val: 1'b0};
    end else begin
      st_q   <= st_d;
      addr_q <= addr_d;
      last_q <= last_d;
      hit_q  <= hit_d;
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      ctl_q  <= ctl_d;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bra_checker.sv -----
// Port checker for the bitmap run allocator core, bound to the top level.
`default_nettype none
module bra_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  // Never ready for input while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  // An accepted item is never answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

  // Padding bits of the result stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:14] == 2'b00)) else $error("pad bits set");

  // Result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
endmodule

bind bitmap_run_allocator_core bra_checker u_bra_checker (.*);
`default_nettype wire
